@@ rtl/dsp_pkg.sv @@
// shared constants and state encoding for the shortest path core
package dsp_pkg;

	localparam int VERTEX_W = 6;
	localparam int WEIGHT_W = 4;
	localparam int COST_W = 10;
	localparam int DEF_VERTICES = 64;

	localparam logic [COST_W-1:0] NO_PATH = 10'd999;

	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_INIT    = 6'b000100,
		ST_RELAX   = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_LD = 6'b100000
	} dsp_state_t;

endpackage

@@ rtl/dijkstra_shortest_paths_core.sv @@
// single-source shortest path core over a stored adjacency matrix
// edge write: taken only in idle
// run: init pass over all vertices, then one relax pass per settled vertex,
// then per result a vertex ram read and an output load, held while the output is stalled
// reset: the adjacency ram is cleared by a sweep over all VERTICES*2**clog2(VERTICES) entries
// (4096 at 64 vertices) with item_stall high
module dijkstra_shortest_paths_core
	import dsp_pkg::*;
#(
	parameter int VERTICES = DEF_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                action,
	input  logic [VERTEX_W-1:0] from_vertex,
	input  logic [VERTEX_W-1:0] to_vertex,
	input  logic [WEIGHT_W-1:0] edge_weight,
	input  logic [VERTEX_W-1:0] start_vertex,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [VERTEX_W-1:0] vertex,
	output logic [VERTEX_W-1:0] predecessor,
	output logic                is_start,
	output logic [COST_W-1:0]   path_cost,
	output logic                last
);

	localparam int IW = $clog2(VERTICES);
	localparam int AW = 2 * IW;
	localparam int EDGE_DEPTH = VERTICES * (2 ** IW);
	localparam int VW_W = COST_W + 1 + IW;

	dsp_state_t state_q;

	logic [AW-1:0]     clr_q;
	logic [IW:0]       idx_q;
	logic              v_s1;
	logic [IW-1:0]     i_s1;
	logic [IW-1:0]     s_q;
	logic [IW-1:0]     pick_q;
	logic [COST_W-1:0] low_q;
	logic              nfound_q;
	logic [IW-1:0]     npick_q;
	logic [COST_W-1:0] nlow_q;

	logic              result_valid_q;
	logic [VERTEX_W-1:0] vertex_q;
	logic [VERTEX_W-1:0] pred_q;
	logic              is_start_q;
	logic [COST_W-1:0] cost_q;
	logic              last_q;

	// edge ram ports
	logic              e_we;
	logic [AW-1:0]     e_waddr;
	logic [WEIGHT_W-1:0] e_wdata;
	logic              e_re;
	logic [AW-1:0]     e_raddr;
	logic [WEIGHT_W-1:0] e_rdata;

	// vertex ram ports
	logic              v_we;
	logic [IW-1:0]     v_waddr;
	logic [VW_W-1:0]   v_wdata;
	logic              v_re;
	logic [IW-1:0]     v_raddr;
	logic [VW_W-1:0]   v_rdata;

	logic              in_xfer;
	logic              edge_go;
	logic              run_go;
	logic              in_pass;
	logic              issue;
	logic              pass_end;
	logic              emit_load;
	logic              emit_last;

	logic [COST_W-1:0] vr_cost;
	logic              vr_set;
	logic [IW-1:0]     vr_prev;
	logic [COST_W-1:0] link;
	logic [COST_W:0]   cand;
	logic              cand_ok;
	logic [COST_W-1:0] cand_val;
	logic              take;
	logic              fin_found;
	logic [IW-1:0]     fin_pick;
	logic [COST_W-1:0] fin_low;

	assign item_stall = (state_q != ST_IDLE);
	assign in_xfer = item_valid && !item_stall;
	assign edge_go = in_xfer && (action == ACT_EDGE) && (32'(from_vertex) < VERTICES)
		&& (32'(to_vertex) < VERTICES);
	assign run_go = in_xfer && (action == ACT_RUN) && (32'(start_vertex) < VERTICES);

	assign in_pass = (state_q == ST_INIT) || (state_q == ST_RELAX);
	assign issue = in_pass && (idx_q != (IW+1)'(VERTICES));
	assign pass_end = v_s1 && (i_s1 == IW'(VERTICES - 1));

	assign emit_load = (state_q == ST_EMIT_LD) && (!result_valid_q || !result_stall);
	assign emit_last = (idx_q[IW-1:0] == IW'(VERTICES - 1));

	// edge ram: clearing sweep or edge write, read by init and relax passes
	assign e_we = (state_q == ST_CLEAR) || edge_go;
	assign e_waddr = (state_q == ST_CLEAR) ? clr_q : {IW'(from_vertex), IW'(to_vertex)};
	assign e_wdata = (state_q == ST_CLEAR) ? '0 : edge_weight;
	assign e_re = issue;
	assign e_raddr = {((state_q == ST_INIT) ? s_q : pick_q), idx_q[IW-1:0]};

	assign v_re = (issue && (state_q == ST_RELAX)) || (state_q == ST_EMIT_RD);
	assign v_raddr = idx_q[IW-1:0];
	assign v_waddr = i_s1;

	assign vr_cost = v_rdata[VW_W-1 -: COST_W];
	assign vr_set = v_rdata[IW];
	assign vr_prev = v_rdata[IW-1:0];

	assign link = (e_rdata == '0) ? NO_PATH : COST_W'(e_rdata);
	assign cand = {1'b0, low_q} + {1'b0, link};

	always_comb begin
		v_we = 1'b0;
		v_wdata = {vr_cost, vr_set, vr_prev};
		cand_ok = 1'b0;
		cand_val = vr_cost;
		if (v_s1 && (state_q == ST_INIT)) begin
			v_we = 1'b1;
			if (i_s1 == s_q) begin
				v_wdata = {{COST_W{1'b0}}, 1'b1, s_q};
			end else begin
				v_wdata = {link, 1'b0, s_q};
				cand_ok = 1'b1;
				cand_val = link;
			end
		end else if (v_s1 && (state_q == ST_RELAX) && !vr_set) begin
			priority if (i_s1 == pick_q) begin
				v_we = 1'b1;
				v_wdata = {vr_cost, 1'b1, vr_prev};
			end else if (cand < {1'b0, vr_cost}) begin
				v_we = 1'b1;
				v_wdata = {cand[COST_W-1:0], 1'b0, pick_q};
				cand_ok = 1'b1;
				cand_val = cand[COST_W-1:0];
			end else begin
				cand_ok = 1'b1;
				cand_val = vr_cost;
			end
		end
	end

	// running minimum over the pass, lowest index wins ties
	assign take = cand_ok && (cand_val < nlow_q);
	assign fin_found = nfound_q || take;
	assign fin_pick = take ? i_s1 : npick_q;
	assign fin_low = take ? cand_val : nlow_q;

	dsp_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(EDGE_DEPTH)
	) u_edge_ram (
		.clk    (clk),
		.wr_en  (e_we),
		.wr_addr(e_waddr),
		.wr_data(e_wdata),
		.rd_en  (e_re),
		.rd_addr(e_raddr),
		.rd_data(e_rdata)
	);

	dsp_ram #(
		.WIDTH(VW_W),
		.DEPTH(VERTICES)
	) u_vertex_ram (
		.clk    (clk),
		.wr_en  (v_we),
		.wr_addr(v_waddr),
		.wr_data(v_wdata),
		.rd_en  (v_re),
		.rd_addr(v_raddr),
		.rd_data(v_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			v_s1 <= 1'b0;
			nfound_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(EDGE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (run_go) begin
						idx_q <= '0;
						nfound_q <= 1'b0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT, ST_RELAX: begin
					if (pass_end) begin
						idx_q <= '0;
						nfound_q <= 1'b0;
						state_q <= fin_found ? ST_RELAX : ST_EMIT_RD;
					end else begin
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
						if (take) begin
							nfound_q <= 1'b1;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (emit_load) begin
						idx_q <= idx_q + 1'b1;
						state_q <= emit_last ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= idx_q[IW-1:0];
		if (run_go) begin
			s_q <= IW'(start_vertex);
			nlow_q <= NO_PATH;
		end
		if (in_pass && pass_end) begin
			nlow_q <= NO_PATH;
			pick_q <= fin_pick;
			low_q <= fin_low;
		end else if (in_pass && take) begin
			nlow_q <= cand_val;
			npick_q <= i_s1;
		end
		if (emit_load) begin
			vertex_q <= VERTEX_W'(idx_q[IW-1:0]);
			pred_q <= VERTEX_W'(vr_prev);
			is_start_q <= (idx_q[IW-1:0] == s_q);
			cost_q <= vr_cost;
			last_q <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign vertex = vertex_q;
	assign predecessor = pred_q;
	assign is_start = is_start_q;
	assign path_cost = cost_q;
	assign last = last_q;

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT_LD))
		else $error("result raised outside emit");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !result_valid)
		else $error("result during clearing sweep");

	a_pipe_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_INIT || state_q == ST_RELAX))
		else $error("pass pipeline busy outside a pass");

	a_pick_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RELAX) |-> (low_q < NO_PATH))
		else $error("relax pass on an unreachable vertex");

endmodule

@@ rtl/dsp_ram.sv @@
// generic single write port, single read port ram with registered read
module dsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
